// ----- hw/rtl/gspd_pkg.sv -----
`default_nettype none

package gspd_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS  = 8;
    localparam int GAIN_FRAC  = 16;
    localparam int INTEGRAL_W = 40;

    // Field widths
    localparam int ADC_W    = 16;
    localparam int ECHO_W   = 15;
    localparam int DRIVE_W  = 11;
    localparam int TARGET_W = 15;
    localparam int MEAS_W   = 17;
    localparam int ERR_W    = 18;
    localparam int GAIN_W   = 24;
    localparam int PER_W    = 10;
    localparam int CODE_W   = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 8'd3;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd327680;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd66;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd131072;
    localparam logic [PER_W-1:0]  PERIOD_RST     = 10'd25;

    // Input conditioning
    localparam int CODE_LIMIT   = 1800;
    localparam int CODE_DIVISOR = 1742;
    localparam int ECHO_LIMIT   = 18500;
    localparam int DIST_DIVISOR = 1000;
    localparam int SP_SCALE     = 100 * (1 << FRAC_BITS);
    localparam int ECHO_SCALE   = 17 * (1 << FRAC_BITS);

    // Rounded-up reciprocals of the constant divisions; the floors are exact over
    // codes 0..1800 and echoes 0..18500
    localparam int     SP_SHIFT   = 21;
    localparam int     MEAS_SHIFT = 22;
    localparam longint SP_RECIP   =
        ((longint'(1) << SP_SHIFT) * SP_SCALE + CODE_DIVISOR - 1) / CODE_DIVISOR;
    localparam longint MEAS_RECIP =
        ((longint'(1) << MEAS_SHIFT) * ECHO_SCALE + DIST_DIVISOR - 1) / DIST_DIVISOR;

    // Setpoint clamp and scheduling bands, in 1/2^FRAC_BITS cm
    localparam int SP_MIN     = 5 * (1 << FRAC_BITS);
    localparam int SP_MAX     = 90 * (1 << FRAC_BITS);
    localparam int BAND1_LO   = 50 * (1 << FRAC_BITS);
    localparam int BAND1_HI   = 60 * (1 << FRAC_BITS);
    localparam int BAND2_HI   = 80 * (1 << FRAC_BITS);

    localparam logic [GAIN_W-1:0] BAND1_KP = 24'd196608;
    localparam logic [GAIN_W-1:0] BAND1_KI = 24'd66;
    localparam logic [GAIN_W-1:0] BAND1_KD = 24'd3276800;
    localparam logic [GAIN_W-1:0] BAND2_KP = 24'd327680;
    localparam logic [GAIN_W-1:0] BAND2_KI = 24'd72;
    localparam logic [GAIN_W-1:0] BAND2_KD = 24'd4587520;

    localparam int DRIVE_MAX = 1024;

    // Shared multiplier
    localparam int MUL_A_W = 29;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TERM_W  = 43;

    // Restoring divider
    localparam int DIV_W     = 42;
    localparam int DIVISOR_W = 11;
    localparam int DIV_CNT_W = 6;

    // Integral saturation limits
    localparam logic signed [INTEGRAL_W-1:0] INT_MAX = {1'b0, {(INTEGRAL_W-1){1'b1}}};
    localparam logic signed [INTEGRAL_W-1:0] INT_MIN = {1'b1, {(INTEGRAL_W-1){1'b0}}};

    localparam int ISUM_W = ((INTEGRAL_W > PROD_W) ? INTEGRAL_W : PROD_W) + 1;
    localparam int SUM_W  = ((INTEGRAL_W > TERM_W) ? INTEGRAL_W : TERM_W) + 2;

endpackage

`default_nettype wire

// ----- hw/rtl/gain_scheduled_pid_distance.sv -----
`default_nettype none

// Channel  Ports                                   Direction  Payload
// -------  --------------------------------------  ---------  ---------------------------------
// s_       s_valid, s_ready                        in         s_adc_word, s_echo_us
// m_       m_valid, m_ready                        out        m_drive, m_target_dist,
//                                                             m_measured_dist, m_control_error
// cfg_     cfg_valid, cfg_ready                    in         cfg_index, cfg_data
//
// A request runs from acceptance to result through one 42-step pass of the restoring
// divider (derivative) plus eleven sequencer steps around the shared 29x25
// multiplier, which also does the setpoint and distance divisions by reciprocal.
// s_ready is high only while the sequencer is idle, so no request is taken while one is in flight.
// A new request holds in its final step only if the previous result has not been taken.
// aresetn (synchronous) restores the register defaults and clears integral and last error.

module gain_scheduled_pid_distance (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [gspd_pkg::ADC_W-1:0]          s_adc_word,
    input  wire logic [gspd_pkg::ECHO_W-1:0]         s_echo_us,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [gspd_pkg::DRIVE_W-1:0]             m_drive,
    output logic [gspd_pkg::TARGET_W-1:0]            m_target_dist,
    output logic [gspd_pkg::MEAS_W-1:0]              m_measured_dist,
    output logic signed [gspd_pkg::ERR_W-1:0]        m_control_error,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gspd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gspd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gspd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP_MUL,
        ST_MS_MUL,
        ST_ERR,
        ST_P_MUL,
        ST_EP_MUL,
        ST_I_MUL,
        ST_I_ADD,
        ST_D_MUL,
        ST_D_LOAD,
        ST_D_DIV,
        ST_SUM,
        ST_FIN
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [GAIN_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [PER_W-1:0]  period_reg;

    // Per-request working registers
    logic [CODE_W-1:0]          code_reg;
    logic [ECHO_W-1:0]          echo_reg;
    logic [TARGET_W-1:0]        sp_reg;
    logic [MEAS_W-1:0]          meas_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic [GAIN_W-1:0]          kp_reg, ki_reg, kd_reg;
    logic [PER_W-1:0]           per_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [TERM_W-1:0]   pterm_reg;
    logic signed [TERM_W:0]     pd_reg;
    logic                       dneg_reg;

    // Controller state
    logic signed [INTEGRAL_W-1:0] integral_reg;
    logic signed [ERR_W-1:0]      last_err_reg;

    // Divider
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    // Output register
    logic                     m_valid_reg;
    logic [DRIVE_W-1:0]       drive_reg;
    logic [TARGET_W-1:0]      target_reg;
    logic [MEAS_W-1:0]        measured_reg;
    logic signed [ERR_W-1:0]  error_reg;

    // Input conditioning: swap bytes, keep the 12-bit code, zero out-of-range codes
    logic [11:0]        code_raw;
    logic [CODE_W-1:0]  code_flt;
    logic [ECHO_W-1:0]  echo_sat;

    assign code_raw = {s_adc_word[7:0], s_adc_word[15:12]};
    assign code_flt = (code_raw > 12'(CODE_LIMIT)) ? '0 : code_raw[CODE_W-1:0];
    assign echo_sat = (s_echo_us > ECHO_W'(ECHO_LIMIT)) ? ECHO_W'(ECHO_LIMIT) : s_echo_us;

    // Shared multiplier operand select
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [ERR_W:0]     err_diff;

    assign err_diff = {err_reg[ERR_W-1], err_reg} - {last_err_reg[ERR_W-1], last_err_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SP_MUL: begin
                mul_a = MUL_A_W'(SP_RECIP);
                mul_b = signed'(MUL_B_W'(code_reg));
            end
            ST_MS_MUL: begin
                mul_a = MUL_A_W'(MEAS_RECIP);
                mul_b = signed'(MUL_B_W'(echo_reg));
            end
            ST_P_MUL: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = signed'({1'b0, kp_reg});
            end
            ST_EP_MUL: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = signed'(MUL_B_W'(per_reg));
            end
            ST_I_MUL: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = signed'({1'b0, ki_reg});
            end
            ST_D_MUL: begin
                mul_a = MUL_A_W'(err_diff);
                mul_b = signed'({1'b0, kd_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Divider step: shift in one dividend bit, subtract when it fits
    logic [DIVISOR_W:0]   div_shift;
    logic                 div_ge;
    logic [DIVISOR_W:0]   div_diff;
    logic [DIVISOR_W-1:0] rem_step;

    assign div_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_diff  = div_shift - {1'b0, divisor_reg};
    assign rem_step  = div_ge ? div_diff[DIVISOR_W-1:0] : div_shift[DIVISOR_W-1:0];

    // Setpoint quotient from the reciprocal product, then clamp
    logic [PROD_W-SP_SHIFT-1:0] sp_quo;
    logic [TARGET_W-1:0]        sp_clamp;

    assign sp_quo   = prod_reg[PROD_W-1:SP_SHIFT];
    assign sp_clamp = (sp_quo < (PROD_W-SP_SHIFT)'(SP_MIN)) ? TARGET_W'(SP_MIN) :
                      (sp_quo > (PROD_W-SP_SHIFT)'(SP_MAX)) ? TARGET_W'(SP_MAX) :
                      sp_quo[TARGET_W-1:0];

    // Measured distance from the reciprocal product
    logic [MEAS_W-1:0] meas_quo;

    assign meas_quo = prod_reg[MEAS_SHIFT +: MEAS_W];

    // Error and gain schedule
    logic signed [ERR_W-1:0] err_calc;
    logic                    band1, band2;

    assign err_calc = signed'({1'b0, meas_quo}) - signed'(ERR_W'(sp_reg));
    assign band1    = (sp_reg > TARGET_W'(BAND1_LO)) && (sp_reg <= TARGET_W'(BAND1_HI));
    assign band2    = (sp_reg > TARGET_W'(BAND1_HI)) && (sp_reg <= TARGET_W'(BAND2_HI));

    // Saturating integral update
    logic signed [ISUM_W-1:0]     isum;
    logic signed [INTEGRAL_W-1:0] integral_next;

    assign isum = ISUM_W'(integral_reg) + ISUM_W'(prod_reg);

    always_comb begin
        priority if (isum > ISUM_W'(INT_MAX)) begin
            integral_next = INT_MAX;
        end else if (isum < ISUM_W'(INT_MIN)) begin
            integral_next = INT_MIN;
        end else begin
            integral_next = isum[INTEGRAL_W-1:0];
        end
    end

    // Derivative magnitude for the unsigned divider
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [TERM_W-1:0] dterm;

    assign prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign dterm    = dneg_reg ? -signed'({1'b0, quo_reg}) : signed'({1'b0, quo_reg});

    // Final sum and drive clamp
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] total_shift;
    logic [DRIVE_W-1:0]      drive_calc;

    assign total       = SUM_W'(pd_reg) + SUM_W'(integral_reg);
    assign total_shift = total >>> (GAIN_FRAC + FRAC_BITS);

    always_comb begin
        priority if (total < 0) begin
            drive_calc = '0;
        end else if (total_shift > SUM_W'(DRIVE_MAX)) begin
            drive_calc = DRIVE_W'(DRIVE_MAX);
        end else begin
            drive_calc = total_shift[DRIVE_W-1:0];
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            period_reg     <= PERIOD_RST;
            integral_reg   <= '0;
            last_err_reg   <= '0;
            cnt_reg        <= '0;
        end else begin
            // Register writes; unknown indexes drop
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                    REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                    REG_PERIOD:     period_reg     <= cfg_data[PER_W-1:0];
                    default: ;
                endcase
            end

            // Release the result once taken
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        code_reg  <= code_flt;
                        echo_reg  <= echo_sat;
                        state_reg <= ST_SP_MUL;
                    end
                end
                ST_SP_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_MS_MUL;
                end
                ST_MS_MUL: begin
                    sp_reg    <= sp_clamp;
                    prod_reg  <= mul_prod;
                    state_reg <= ST_ERR;
                end
                ST_ERR: begin
                    meas_reg <= meas_quo;
                    err_reg  <= err_calc;
                    per_reg  <= (period_reg == '0) ? PER_W'(1) : period_reg;
                    priority if (band1) begin
                        kp_reg <= BAND1_KP;
                        ki_reg <= BAND1_KI;
                        kd_reg <= BAND1_KD;
                    end else if (band2) begin
                        kp_reg <= BAND2_KP;
                        ki_reg <= BAND2_KI;
                        kd_reg <= BAND2_KD;
                    end else begin
                        kp_reg <= prop_gain_reg;
                        ki_reg <= integ_gain_reg;
                        kd_reg <= deriv_gain_reg;
                    end
                    state_reg <= ST_P_MUL;
                end
                ST_P_MUL: begin
                    pterm_reg <= mul_prod[TERM_W-1:0];
                    state_reg <= ST_EP_MUL;
                end
                ST_EP_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_I_MUL;
                end
                ST_I_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_I_ADD;
                end
                ST_I_ADD: begin
                    integral_reg <= integral_next;
                    state_reg    <= ST_D_MUL;
                end
                ST_D_MUL: begin
                    prod_reg     <= mul_prod;
                    last_err_reg <= err_reg;
                    state_reg    <= ST_D_LOAD;
                end
                ST_D_LOAD: begin
                    quo_reg     <= prod_abs[DIV_W-1:0];
                    dneg_reg    <= prod_reg[PROD_W-1];
                    rem_reg     <= '0;
                    divisor_reg <= DIVISOR_W'(per_reg);
                    cnt_reg     <= DIV_CNT_W'(DIV_W - 1);
                    state_reg   <= ST_D_DIV;
                end
                ST_D_DIV: begin
                    rem_reg <= rem_step;
                    quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    pd_reg    <= (TERM_W+1)'(pterm_reg) + (TERM_W+1)'(dterm);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        drive_reg    <= drive_calc;
                        target_reg   <= sp_reg;
                        measured_reg <= meas_reg;
                        error_reg    <= err_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_drive         = drive_reg;
    assign m_target_dist   = target_reg;
    assign m_measured_dist = measured_reg;
    assign m_control_error = error_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer took a request but stayed ready");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_D_DIV) |-> (divisor_reg != '0))
        else $error("divider running with a zero divisor");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive <= DRIVE_W'(DRIVE_MAX)))
        else $error("drive above clamp");

    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_target_dist >= TARGET_W'(SP_MIN) && m_target_dist <= TARGET_W'(SP_MAX)))
        else $error("setpoint outside clamp range");

endmodule

`default_nettype wire
